// ===== src/lmim_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmim_pkg
// Shared types, constants and helpers of the LED matrix index mapper.
// ============================================================================
package lmim_pkg;

    localparam int MAX_DIM    = 256;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int IDX_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;
    localparam int DIV_STAGES = IDX_W;
    localparam int MAP_STAGES = 2;
    localparam int LATENCY    = DIV_STAGES + MAP_STAGES;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_CORNER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_MAJOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SERPENTINE_ON = 3'd5;

    localparam logic [DIM_W-1:0] GRID_DIM_RESET = DIM_W'(16);

    // Origin corner bits: bit 0 mirrors x, bit 1 mirrors y
    localparam int CORNER_RIGHT_BIT  = 0;
    localparam int CORNER_BOTTOM_BIT = 1;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        rot_t             rotation;
        logic [1:0]       corner;
        logic             column_major;
        logic             serpentine_on;
    } map_cfg_t;

    // One slot of the divider chain
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] dvd;
        logic [DIM_W-1:0] rem;
        logic [IDX_W-1:0] quo;
    } div_slot_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
    endfunction

endpackage

// ===== src/lmim_div_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmim_div_cell
// One restoring-division step: shift in the next dividend bit, subtract the
// width when it fits, shift the quotient bit in.
// ============================================================================
module lmim_div_cell
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [lmim_pkg::DIM_W-1:0] divisor,
    input  lmim_pkg::div_slot_t      slot_in,
    output lmim_pkg::div_slot_t      slot_out
);
    import lmim_pkg::*;

    logic [DIM_W:0]   trial;
    logic [DIM_W:0]   diff;
    logic             fits;
    div_slot_t        slot_next;
    logic             valid_reg;
    div_slot_t        data_reg;

    always_comb
    begin
        trial = {slot_in.rem, slot_in.dvd[IDX_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
        slot_next       = slot_in;
        slot_next.dvd   = {slot_in.dvd[IDX_W-2:0], 1'b0};
        slot_next.rem   = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
        slot_next.quo   = {slot_in.quo[IDX_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= slot_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= slot_next;
    end

    always_comb
    begin
        slot_out       = data_reg;
        slot_out.valid = valid_reg;
    end

endmodule

// ===== src/lmim_place.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmim_place
// Rotate, mirror and serpentine-fold the split coordinates, then form the
// strip position with one multiply-add.
// ============================================================================
module lmim_place
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lmim_pkg::map_cfg_t         cfg,
    input  lmim_pkg::div_slot_t        slot_in,
    output logic                       done,
    output logic [lmim_pkg::IDX_W-1:0] physical_index,
    output logic                       out_of_range
);
    import lmim_pkg::*;

    logic [IDX_W-1:0]       w16, h16, lx, ly;
    logic [IDX_W-1:0]       rx, ry, ox, oy;
    logic [DIM_W-1:0]       pw, ph;
    logic [IDX_W-1:0]       pw16, ph16;
    logic [IDX_W-1:0]       major, minor;
    logic [DIM_W-1:0]       span;
    logic [2*DIM_W-1:0]     area;
    logic                   oor;
    logic                   zero_dim;

    logic                   a_valid_reg;
    logic [IDX_W-1:0]       a_major_reg, a_minor_reg;
    logic [DIM_W-1:0]       a_span_reg;
    logic                   a_oor_reg, a_zero_reg;

    logic [IDX_W+DIM_W-1:0] prod;
    logic [IDX_W-1:0]       res;

    logic                   done_reg;
    logic [IDX_W-1:0]       phys_reg;
    logic                   oor_reg;

    always_comb
    begin
        w16 = IDX_W'(cfg.width);
        h16 = IDX_W'(cfg.height);
        lx  = IDX_W'(slot_in.rem);
        ly  = slot_in.quo;

        case (cfg.rotation)
            ROT_90:
            begin
                rx = h16 - 1'b1 - ly;  ry = lx;
                pw = cfg.height;       ph = cfg.width;
            end
            ROT_180:
            begin
                rx = w16 - 1'b1 - lx;  ry = h16 - 1'b1 - ly;
                pw = cfg.width;        ph = cfg.height;
            end
            ROT_270:
            begin
                rx = ly;               ry = w16 - 1'b1 - lx;
                pw = cfg.height;       ph = cfg.width;
            end
            default:
            begin
                rx = lx;               ry = ly;
                pw = cfg.width;        ph = cfg.height;
            end
        endcase

        pw16 = IDX_W'(pw);
        ph16 = IDX_W'(ph);
        ox = cfg.corner[CORNER_RIGHT_BIT]  ? (pw16 - 1'b1 - rx) : rx;
        oy = cfg.corner[CORNER_BOTTOM_BIT] ? (ph16 - 1'b1 - ry) : ry;

        if (cfg.column_major)
        begin
            major = ox;
            span  = ph;
            minor = (cfg.serpentine_on && ox[0]) ? (ph16 - 1'b1 - oy) : oy;
        end
        else
        begin
            major = oy;
            span  = pw;
            minor = (cfg.serpentine_on && oy[0]) ? (pw16 - 1'b1 - ox) : ox;
        end

        area     = {{DIM_W{1'b0}}, cfg.width} * {{DIM_W{1'b0}}, cfg.height};
        oor      = ((2*DIM_W)'(slot_in.idx) >= area);
        zero_dim = (cfg.width == '0) || (cfg.height == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= slot_in.valid;
            done_reg    <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_major_reg <= major;
        a_minor_reg <= minor;
        a_span_reg  <= span;
        a_oor_reg   <= oor;
        a_zero_reg  <= zero_dim;
    end

    always_comb
    begin
        prod = {{DIM_W{1'b0}}, a_major_reg} * {{IDX_W{1'b0}}, a_span_reg};
        res  = a_zero_reg ? '0 : (prod[IDX_W-1:0] + a_minor_reg);
    end

    always_ff @(posedge clk)
    begin
        phys_reg <= res;
        oor_reg  <= a_oor_reg;
    end

    assign done           = done_reg;
    assign physical_index = phys_reg;
    assign out_of_range   = oor_reg;

endmodule

// ===== src/led_matrix_index_map_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// led_matrix_index_map_core
// Maps a row-major logical pixel index to the LED position along the strip.
// ============================================================================
// Usage:
//   Input channel: drive logical_index and raise start; the item is taken at
//   every rising edge with start high and busy low. busy is always low, so a
//   new item may enter in every cycle.
//   Result channel: done pulses for one cycle with physical_index and
//   out_of_range. The receiver cannot stall it; every item gives exactly one
//   result, in order.
//   Pipeline: an item passes through 16 division cells, one placement stage
//   and one multiply-add stage. Throughput: one item per cycle.
//   The x/y split is a chain of 16 restoring-division cells, one quotient bit
//   per cell, each cell handing its partial remainder to the next.
//   Configuration: write register cfg_index with cfg_data when cfg_valid is
//   high; cfg_ready is always high. Write only while no item is in flight.
//   Reset: grid 16 x 16, no rotation, top-left origin, row-major, no
//   serpentine; the pipeline is emptied at once.
// ============================================================================
module led_matrix_index_map_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lmim_pkg::IDX_W-1:0]      logical_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lmim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmim_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic [lmim_pkg::IDX_W-1:0]      physical_index,
    output logic                            out_of_range
);
    import lmim_pkg::*;

    map_cfg_t  cfg_reg;
    map_cfg_t  cfg_eff;
    div_slot_t slot [DIV_STAGES+1];

    // The pipeline never holds items back
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width         <= GRID_DIM_RESET;
            cfg_reg.height        <= GRID_DIM_RESET;
            cfg_reg.rotation      <= ROT_0;
            cfg_reg.corner        <= 2'b00;
            cfg_reg.column_major  <= 1'b0;
            cfg_reg.serpentine_on <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:    cfg_reg.width         <= cfg_data;
                REG_GRID_HEIGHT:   cfg_reg.height        <= cfg_data;
                REG_ROTATION_CODE: cfg_reg.rotation      <= rot_t'(cfg_data[1:0]);
                REG_ORIGIN_CORNER: cfg_reg.corner        <= cfg_data[1:0];
                REG_COLUMN_MAJOR:  cfg_reg.column_major  <= cfg_data[0];
                REG_SERPENTINE_ON: cfg_reg.serpentine_on <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Clamp oversized dimensions to the largest supported grid
    always_comb
    begin
        cfg_eff        = cfg_reg;
        cfg_eff.width  = clamp_dim(cfg_reg.width);
        cfg_eff.height = clamp_dim(cfg_reg.height);
    end

    // Seed the division chain: full index as dividend, empty remainder
    always_comb
    begin
        slot[0].valid = start && !busy;
        slot[0].idx   = logical_index;
        slot[0].dvd   = logical_index;
        slot[0].rem   = '0;
        slot[0].quo   = '0;
    end

    // One quotient bit per cell, remainder handed to the neighbor each cycle
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        lmim_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .divisor  (cfg_eff.width),
            .slot_in  (slot[i]),
            .slot_out (slot[i+1])
        );
    end

    // Rotate, mirror, fold and place along the strip
    lmim_place u_place
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_eff),
        .slot_in        (slot[DIV_STAGES]),
        .done           (done),
        .physical_index (physical_index),
        .out_of_range   (out_of_range)
    );

endmodule

// ===== src/lmim_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmim_checker
// Port-level checks of the index mapper: fixed latency, no lost or invented
// results, configuration always taken, no unknown bits in payloads or results.
// ============================================================================
module lmim_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [lmim_pkg::IDX_W-1:0]      logical_index,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [lmim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [lmim_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                            done,
    input logic [lmim_pkg::IDX_W-1:0]      physical_index,
    input logic                            out_of_range
);
    import lmim_pkg::*;

    // Every accepted item yields its result after the fixed latency
    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not produce a result");

    // No result without an item accepted the fixed latency earlier
    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    // Configuration writes are never refused
    a_cfg_always_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write was refused");

    // Results carry no unknown bits
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({physical_index, out_of_range}))
        else $error("result fields unknown");

    // Accepted items and writes carry known payloads
    a_input_known: assert property (@(posedge clk) disable iff (!rst_n)
        ((start && !busy) || (cfg_valid && cfg_ready))
            |-> !$isunknown({logical_index, cfg_index, cfg_data}))
        else $error("accepted payload unknown");

endmodule

bind led_matrix_index_map_core lmim_checker u_lmim_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .logical_index  (logical_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .physical_index (physical_index),
    .out_of_range   (out_of_range)
);
